FILE: rtl/nvt_pkg.sv
// ----------------------------------------------------------------------------
// nvt_pkg
// Shared widths, register codes, item types and step functions of the
// normal vector transform unit.
// ----------------------------------------------------------------------------
package nvt_pkg;

  localparam int unsigned CompW   = 16;
  localparam int unsigned RegW    = 48;
  localparam int unsigned RegIdxW = 2;

  localparam logic [RegIdxW-1:0] RegBasisFirst  = 2'd0;
  localparam logic [RegIdxW-1:0] RegBasisSecond = 2'd1;
  localparam logic [RegIdxW-1:0] RegBasisThird  = 2'd2;

  localparam logic [RegW-1:0] ResetBasisFirst  = 48'h0000_0000_1000;
  localparam logic [RegW-1:0] ResetBasisSecond = 48'h0000_1000_0000;
  localparam logic [RegW-1:0] ResetBasisThird  = 48'h1000_0000_0000;

  localparam int unsigned CofW  = 33;
  localparam int unsigned ProdW = 49;
  localparam int unsigned RW    = 50;
  localparam int unsigned MagW  = 48;
  localparam int unsigned NrmW  = 30;
  localparam int unsigned SqW   = 62;
  localparam int unsigned RootW = 31;
  localparam int unsigned RemW  = RootW + 2;
  localparam int unsigned FracW = 14;
  localparam int unsigned QW    = 15;
  localparam int unsigned NumW  = NrmW + FracW + 1;

  localparam int unsigned ChunkW = 8;
  localparam int unsigned Chunks = MagW / ChunkW;
  localparam int unsigned PosW   = 6;

  localparam int unsigned SqrtSteps  = RootW;
  localparam int unsigned SqrtStages = (SqrtSteps + 1) / 2;
  localparam int unsigned DivSteps   = QW;
  localparam int unsigned DivStages  = (DivSteps + 1) / 2;

  localparam logic [QW-1:0] QMax = QW'(1 << FracW);

  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic                 zero;
  } wide_t;

  typedef struct packed {
    logic [2:0][NrmW-1:0] mag;
    logic [2:0]           neg;
    logic                 zero;
  } side_t;

  typedef struct packed {
    logic [2:0][CompW-1:0] unit;
    logic                  degenerate;
  } res_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [RootW-1:0] rem;
    logic [QW-1:0]    q;
  } dv_t;

  function automatic logic signed [CofW-1:0] cof_term(
    logic signed [CompW-1:0] a, logic signed [CompW-1:0] b,
    logic signed [CompW-1:0] c, logic signed [CompW-1:0] d);
    logic signed [2*CompW-1:0] p;
    logic signed [2*CompW-1:0] q;
    p = a * b;
    q = c * d;
    return $signed({p[2*CompW-1], p}) - $signed({q[2*CompW-1], q});
  endfunction

  function automatic sq_t sqrt_step(sq_t a, logic [1:0] pair);
    logic [RemW+1:0] t;
    logic [RemW+1:0] trial;
    sq_t r;
    t     = {a.rem, pair};
    trial = {2'b00, a.root, 2'b01};
    if (t >= trial) begin
      r.rem  = RemW'(t - trial);
      r.root = {a.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = t[RemW-1:0];
      r.root = {a.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t div_step(dv_t a, logic [RootW-1:0] n, logic b);
    logic [RootW:0] t;
    dv_t r;
    t = {a.rem, b};
    if (t >= {1'b0, n}) begin
      r.rem = RootW'(t - {1'b0, n});
      r.q   = {a.q[QW-2:0], 1'b1};
    end else begin
      r.rem = t[RootW-1:0];
      r.q   = {a.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/normal_vector_transform_unit.sv
// ----------------------------------------------------------------------------
// normal_vector_transform_unit
// Transforms surface normals by the cofactor form of a configured basis and
// scales them to unit length.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  normal_x/y/z_i
//   out      output     out_valid_o / out_stall_i unit_x/y/z_o, degenerate_o
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; the depth is set mostly by
// the 16-stage square root and 10-stage divider.
// Reset clears all valid bits and loads the identity basis.
// An output stall holds the result; one more item parks in the skid entry,
// then the whole pipeline freezes and in_stall_o rises.
// ----------------------------------------------------------------------------
module normal_vector_transform_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [nvt_pkg::CompW-1:0]    normal_x_i,
  input  logic signed [nvt_pkg::CompW-1:0]    normal_y_i,
  input  logic signed [nvt_pkg::CompW-1:0]    normal_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [nvt_pkg::CompW-1:0]    unit_x_o,
  output logic signed [nvt_pkg::CompW-1:0]    unit_y_o,
  output logic signed [nvt_pkg::CompW-1:0]    unit_z_o,
  output logic                                degenerate_o,
  input  logic                                cfg_we_i,
  input  logic [nvt_pkg::RegIdxW-1:0]         cfg_idx_i,
  input  logic [nvt_pkg::RegW-1:0]            cfg_data_i
);
  import nvt_pkg::*;

  logic [2:0][RegW-1:0] basis_q;
  logic                 adv;
  logic                 f_v, n_v, s_v, d_v;
  wide_t                f_data;
  side_t                n_side, s_side;
  logic [SqW-1:0]       n_s;
  logic [RootW-1:0]     s_root;
  res_t                 d_res, o_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_q[0] <= ResetBasisFirst;
      basis_q[1] <= ResetBasisSecond;
      basis_q[2] <= ResetBasisThird;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBasisFirst:  basis_q[0] <= cfg_data_i;
        RegBasisSecond: basis_q[1] <= cfg_data_i;
        RegBasisThird:  basis_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nvt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .basis_i (basis_q),
    .valid_i (in_valid_i),
    .nx_i    (normal_x_i),
    .ny_i    (normal_y_i),
    .nz_i    (normal_z_i),
    .valid_o (f_v),
    .data_o  (f_data)
  );

  nvt_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (f_v),
    .data_i  (f_data),
    .valid_o (n_v),
    .side_o  (n_side),
    .s_o     (n_s)
  );

  nvt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (n_v),
    .side_i  (n_side),
    .s_i     (n_s),
    .valid_o (s_v),
    .side_o  (s_side),
    .root_o  (s_root)
  );

  nvt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_v),
    .side_i  (s_side),
    .n_i     (s_root),
    .valid_o (d_v),
    .res_o   (d_res)
  );

  nvt_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_v),
    .res_i   (d_res),
    .adv_o   (adv),
    .valid_o (out_valid_o),
    .res_o   (o_res),
    .stall_i (out_stall_i)
  );

  assign in_stall_o   = !adv;
  assign unit_x_o     = $signed(o_res.unit[0]);
  assign unit_y_o     = $signed(o_res.unit[1]);
  assign unit_z_o     = $signed(o_res.unit[2]);
  assign degenerate_o = o_res.degenerate;

endmodule

FILE: rtl/nvt_front.sv
// ----------------------------------------------------------------------------
// nvt_front
// Cofactor products, weighted sum, determinant sign and magnitudes,
// four register stages.
// ----------------------------------------------------------------------------
module nvt_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    adv_i,
  input  logic [2:0][nvt_pkg::RegW-1:0]           basis_i,
  input  logic                                    valid_i,
  input  logic signed [nvt_pkg::CompW-1:0]        nx_i,
  input  logic signed [nvt_pkg::CompW-1:0]        ny_i,
  input  logic signed [nvt_pkg::CompW-1:0]        nz_i,
  output logic                                    valid_o,
  output nvt_pkg::wide_t                          data_o
);
  import nvt_pkg::*;

  logic signed [CompW-1:0] bx[3], by[3], bz[3];
  logic signed [CofW-1:0]  cyz_q[3], czx_q[3], cxy_q[3];
  logic signed [CompW-1:0] x_q[3], n_q[3];
  logic signed [ProdW-1:0] p_q[3][3], d_q[3];
  logic signed [RW-1:0]    r_q[3];
  logic signed [RW-1:0]    det;
  logic signed [RW-1:0]    ab[3];
  logic                    detneg_q;
  logic                    v1_q, v2_q, v3_q, v4_q;
  wide_t                   out_d, out_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bx[k] = $signed(basis_i[0][k*CompW +: CompW]);
      by[k] = $signed(basis_i[1][k*CompW +: CompW]);
      bz[k] = $signed(basis_i[2][k*CompW +: CompW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cyz_q[0] <= cof_term(by[1], bz[2], by[2], bz[1]);
      cyz_q[1] <= cof_term(by[2], bz[0], by[0], bz[2]);
      cyz_q[2] <= cof_term(by[0], bz[1], by[1], bz[0]);
      czx_q[0] <= cof_term(bz[1], bx[2], bz[2], bx[1]);
      czx_q[1] <= cof_term(bz[2], bx[0], bz[0], bx[2]);
      czx_q[2] <= cof_term(bz[0], bx[1], bz[1], bx[0]);
      cxy_q[0] <= cof_term(bx[1], by[2], bx[2], by[1]);
      cxy_q[1] <= cof_term(bx[2], by[0], bx[0], by[2]);
      cxy_q[2] <= cof_term(bx[0], by[1], bx[1], by[0]);
      for (int k = 0; k < 3; k++) begin
        x_q[k] <= bx[k];
      end
      n_q[0] <= nx_i;
      n_q[1] <= ny_i;
      n_q[2] <= nz_i;
      for (int i = 0; i < 3; i++) begin
        p_q[i][0] <= cyz_q[i] * n_q[0];
        p_q[i][1] <= czx_q[i] * n_q[1];
        p_q[i][2] <= cxy_q[i] * n_q[2];
        d_q[i]    <= x_q[i] * cyz_q[i];
        r_q[i]    <= p_q[i][0] + p_q[i][1] + p_q[i][2];
      end
      detneg_q <= det[RW-1];
      out_q    <= out_d;
    end
  end

  always_comb begin
    det = d_q[0] + d_q[1] + d_q[2];
    for (int i = 0; i < 3; i++) begin
      ab[i]          = r_q[i][RW-1] ? -r_q[i] : r_q[i];
      out_d.mag[i]   = ab[i][MagW-1:0];
      out_d.neg[i]   = r_q[i][RW-1] ^ detneg_q;
    end
    out_d.zero = (r_q[0] == '0) && (r_q[1] == '0) && (r_q[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign valid_o = v4_q;
  assign data_o  = out_q;

endmodule

FILE: rtl/nvt_norm.sv
// ----------------------------------------------------------------------------
// nvt_norm
// Largest magnitude, leading one search, scaling shift and sum of squares,
// six register stages.
// ----------------------------------------------------------------------------
module nvt_norm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  nvt_pkg::wide_t             data_i,
  output logic                       valid_o,
  output nvt_pkg::side_t             side_o,
  output logic [nvt_pkg::SqW-1:0]    s_o
);
  import nvt_pkg::*;

  localparam logic [PosW-1:0] NrmTop = PosW'(NrmW - 1);

  wide_t                d1_q, d2_q, d3_q;
  logic [MagW-1:0]      m_d, m1_q;
  logic [Chunks-1:0]    nz_d, nz2_q;
  logic [2:0]           pos_d[Chunks], pos2_q[Chunks];
  logic [PosW-1:0]      p_d, p3_q;
  logic [MagW-1:0]      wide[3];
  side_t                s4_d, s4_q, s5_q, s6_q;
  logic [2*NrmW-1:0]    sq5_q[3];
  logic [SqW-1:0]       s6v_q;
  logic [5:0]           v_q;

  always_comb begin
    m_d = data_i.mag[0];
    if (data_i.mag[1] > m_d) m_d = data_i.mag[1];
    if (data_i.mag[2] > m_d) m_d = data_i.mag[2];
  end

  always_comb begin
    for (int c = 0; c < Chunks; c++) begin
      nz_d[c]  = |m1_q[c*ChunkW +: ChunkW];
      pos_d[c] = '0;
      for (int b = 0; b < ChunkW; b++) begin
        if (m1_q[c*ChunkW + b]) pos_d[c] = 3'(b);
      end
    end
  end

  always_comb begin
    p_d = '0;
    for (int c = 0; c < Chunks; c++) begin
      if (nz2_q[c]) p_d = PosW'(c * ChunkW) + PosW'(pos2_q[c]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p3_q >= NrmTop) begin
        wide[i] = d3_q.mag[i] >> (p3_q - NrmTop);
      end else begin
        wide[i] = d3_q.mag[i] << (NrmTop - p3_q);
      end
      s4_d.mag[i] = wide[i][NrmW-1:0];
    end
    s4_d.neg  = d3_q.neg;
    s4_d.zero = d3_q.zero;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d1_q  <= data_i;
      m1_q  <= m_d;
      d2_q  <= d1_q;
      nz2_q <= nz_d;
      for (int c = 0; c < Chunks; c++) begin
        pos2_q[c] <= pos_d[c];
      end
      d3_q  <= d2_q;
      p3_q  <= p_d;
      s4_q  <= s4_d;
      s5_q  <= s4_q;
      for (int i = 0; i < 3; i++) begin
        sq5_q[i] <= s4_q.mag[i] * s4_q.mag[i];
      end
      s6_q  <= s5_q;
      s6v_q <= SqW'(sq5_q[0]) + SqW'(sq5_q[1]) + SqW'(sq5_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  assign valid_o = v_q[5];
  assign side_o  = s6_q;
  assign s_o     = s6v_q;

endmodule

FILE: rtl/nvt_sqrt.sv
// ----------------------------------------------------------------------------
// nvt_sqrt
// Pipelined integer square root, two result bits per stage and one in the last.
// ----------------------------------------------------------------------------
module nvt_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  nvt_pkg::side_t              side_i,
  input  logic [nvt_pkg::SqW-1:0]     s_i,
  output logic                        valid_o,
  output nvt_pkg::side_t              side_o,
  output logic [nvt_pkg::RootW-1:0]   root_o
);
  import nvt_pkg::*;

  sq_t            st_q[SqrtStages];
  logic [SqW-1:0] s_q[SqrtStages];
  side_t          side_q[SqrtStages];
  logic           v_q[SqrtStages];

  for (genvar k = 0; k < SqrtStages; k++) begin : g_st
    sq_t            a0, a1, a2;
    logic [SqW-1:0] s_in;
    side_t          side_in;
    logic           v_in;

    if (k == 0) begin : g_first
      assign a0      = '0;
      assign s_in    = s_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign a0      = st_q[k-1];
      assign s_in    = s_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign a1 = sqrt_step(a0, s_in[SqW-1-4*k -: 2]);

    if (2*k + 1 < SqrtSteps) begin : g_two
      assign a2 = sqrt_step(a1, s_in[SqW-3-4*k -: 2]);
    end else begin : g_one
      assign a2 = a1;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[k]   <= a2;
        s_q[k]    <= s_in;
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  assign valid_o = v_q[SqrtStages-1];
  assign side_o  = side_q[SqrtStages-1];
  assign root_o  = st_q[SqrtStages-1].root;

endmodule

FILE: rtl/nvt_div.sv
// ----------------------------------------------------------------------------
// nvt_div
// Rounded division of each magnitude by the length, two quotient bits per
// stage and one in the last, then clamping, sign and zero handling.
// ----------------------------------------------------------------------------
module nvt_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  nvt_pkg::side_t              side_i,
  input  logic [nvt_pkg::RootW-1:0]   n_i,
  output logic                        valid_o,
  output nvt_pkg::res_t               res_o
);
  import nvt_pkg::*;

  logic [NumW-1:0]  num_q[3];
  logic [RootW-1:0] n0_q;
  side_t            side0_q;
  logic             v0_q;

  dv_t              dq[DivStages][3];
  logic [QW-1:0]    lo_q[DivStages][3];
  logic [RootW-1:0] n_q[DivStages];
  side_t            side_q[DivStages];
  logic             v_q[DivStages];

  res_t             res_d, res_q;
  logic             vo_q;
  logic [QW-1:0]    qc[3];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= {1'b0, side_i.mag[i], FracW'(0)} + NumW'(n_i >> 1);
      end
      n0_q    <= n_i;
      side0_q <= side_i;
    end
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_st
    logic [RootW-1:0] n_in;
    side_t            side_in;
    logic             v_in;

    if (k == 0) begin : g_first
      assign n_in    = n0_q;
      assign side_in = side0_q;
      assign v_in    = v0_q;
    end else begin : g_next
      assign n_in    = n_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    for (genvar c = 0; c < 3; c++) begin : g_c
      dv_t           a0, a1, a2;
      logic [QW-1:0] lo_in;

      if (k == 0) begin : g_first
        assign a0.rem = RootW'(num_q[c][NumW-1:QW]);
        assign a0.q   = '0;
        assign lo_in  = num_q[c][QW-1:0];
      end else begin : g_next
        assign a0    = dq[k-1][c];
        assign lo_in = lo_q[k-1][c];
      end

      assign a1 = div_step(a0, n_in, lo_in[QW-1-2*k]);

      if (2*k + 1 < DivSteps) begin : g_two
        assign a2 = div_step(a1, n_in, lo_in[QW-2-2*k]);
      end else begin : g_one
        assign a2 = a1;
      end

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          dq[k][c]   <= a2;
          lo_q[k][c] <= lo_in;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        n_q[k]    <= n_in;
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dq[DivStages-1][i].q > QMax) ? QMax : dq[DivStages-1][i].q;
      if (side_q[DivStages-1].zero) begin
        res_d.unit[i] = '0;
      end else if (side_q[DivStages-1].neg[i]) begin
        res_d.unit[i] = -CompW'(qc[i]);
      end else begin
        res_d.unit[i] = CompW'(qc[i]);
      end
    end
    res_d.degenerate = side_q[DivStages-1].zero;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv_i) begin
      v0_q <= valid_i;
      vo_q <= v_q[DivStages-1];
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule

FILE: rtl/nvt_skid.sv
// ----------------------------------------------------------------------------
// nvt_skid
// Output register with a skid entry; the pipeline advances while the skid
// entry is empty.
// ----------------------------------------------------------------------------
module nvt_skid (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  nvt_pkg::res_t   res_i,
  output logic            adv_o,
  output logic            valid_o,
  output nvt_pkg::res_t   res_o,
  input  logic            stall_i
);
  import nvt_pkg::*;

  logic  out_v_d, out_v_q, skid_v_d, skid_v_q, push;
  res_t  out_d, out_q, skid_d, skid_q;

  assign adv_o = !skid_v_q;
  assign push  = adv_o && valid_i;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (out_v_q && stall_i) begin
      if (push) begin
        skid_v_d = 1'b1;
        skid_d   = res_i;
      end
    end else if (skid_v_q) begin
      out_v_d  = 1'b1;
      out_d    = skid_q;
      skid_v_d = 1'b0;
    end else begin
      out_v_d = push;
      out_d   = res_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  assign valid_o = out_v_q;
  assign res_o   = out_q;

endmodule

FILE: rtl/nvt_checker.sv
// ----------------------------------------------------------------------------
// nvt_checker
// Port-level checks of the normal vector transform unit.
// ----------------------------------------------------------------------------
module nvt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic signed [nvt_pkg::CompW-1:0]    normal_x_i,
  input logic signed [nvt_pkg::CompW-1:0]    normal_y_i,
  input logic signed [nvt_pkg::CompW-1:0]    normal_z_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [nvt_pkg::CompW-1:0]    unit_x_o,
  input logic signed [nvt_pkg::CompW-1:0]    unit_y_o,
  input logic signed [nvt_pkg::CompW-1:0]    unit_z_o,
  input logic                                degenerate_o,
  input logic                                cfg_we_i,
  input logic [nvt_pkg::RegIdxW-1:0]         cfg_idx_i,
  input logic [nvt_pkg::RegW-1:0]            cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> unit_x_o == 0 && unit_y_o == 0 && unit_z_o == 0)
    else $error("degenerate result not zero");

  a_unit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |-> unit_x_o != 0 || unit_y_o != 0 || unit_z_o != 0)
    else $error("normalized result is zero");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> unit_x_o <= 16'sd16384 && unit_x_o >= -16'sd16384 &&
                    unit_y_o <= 16'sd16384 && unit_y_o >= -16'sd16384 &&
                    unit_z_o <= 16'sd16384 && unit_z_o >= -16'sd16384)
    else $error("component out of unit range");

endmodule

bind normal_vector_transform_unit nvt_checker u_nvt_checker (.*);
